>>> rtl/stable_sorted_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// Stable sorted priority queue assertion macros
// Concurrent assertion wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define SSPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSPQ_ASSERT(lbl, prop, msg)
`define SSPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/sspq_pkg.sv
// ----------------------------------------------------------------------------
// Stable sorted priority queue package
// Shared widths, codes, controller state and command/status types.
// ----------------------------------------------------------------------------
package sspq_pkg;

    localparam int VALUE_W           = 32;
    localparam int PRIO_IN_W         = 8;
    localparam int STATUS_W          = 2;
    localparam int DEF_CAPACITY      = 16;
    localparam int DEF_PRIORITY_BITS = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic retire;
    } dp_cmd_t;

    typedef struct packed {
        logic res_valid;
    } dp_stat_t;

endpackage

>>> rtl/sspq_in_if.sv
// ----------------------------------------------------------------------------
// Stable sorted priority queue request channel
// Valid/ready channel carrying one insert or remove request per beat.
// ----------------------------------------------------------------------------
interface sspq_in_if;
    import sspq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [VALUE_W-1:0]   value;
    logic [PRIO_IN_W-1:0] priority_req;

    modport source (output valid, output op, output value, output priority_req,
                    input ready);
    modport sink   (input valid, input op, input value, input priority_req,
                    output ready);
endinterface

>>> rtl/sspq_out_if.sv
// ----------------------------------------------------------------------------
// Stable sorted priority queue response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface sspq_out_if #(
    parameter int OCC_W = 5
);
    import sspq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  out_value;
    logic [STATUS_W-1:0]        status;
    logic [OCC_W-1:0]           occupancy;

    modport source (output valid, output out_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input out_value, input status, input occupancy,
                     output ready);
endinterface

>>> rtl/sspq_ctrl.sv
// ----------------------------------------------------------------------------
// Stable sorted priority queue controller
// Sequences capture and execute of one request and frees the result slot.
// ----------------------------------------------------------------------------
module sspq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    input  sspq_pkg::dp_stat_t stat,
    output sspq_pkg::dp_cmd_t  cmd
);
    import sspq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        cmd.retire  = stat.res_valid && out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = !stat.res_valid || out_ready;
                cmd.capture = in_valid && in_ready;
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/sspq_datapath.sv
// ----------------------------------------------------------------------------
// Stable sorted priority queue datapath
// Row of compare-and-shift cells, entry count, request and result registers.
// ----------------------------------------------------------------------------
module sspq_datapath #(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int CNT_W         = 5
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sspq_pkg::dp_cmd_t                     cmd,
    output sspq_pkg::dp_stat_t                    stat,
    input  logic                                  op,
    input  logic [sspq_pkg::VALUE_W-1:0]          value,
    input  logic [sspq_pkg::PRIO_IN_W-1:0]        priority_req,
    output logic signed [sspq_pkg::VALUE_W-1:0]   out_value,
    output logic [sspq_pkg::STATUS_W-1:0]         status,
    output logic [CNT_W-1:0]                      occupancy
);
    import sspq_pkg::*;

    logic [PRIO_IN_W+PRIORITY_BITS-1:0] prio_ext;

    logic                     in_op_reg;
    logic [VALUE_W-1:0]       in_value_reg;
    logic [PRIORITY_BITS-1:0] in_prio_reg;

    logic [VALUE_W-1:0]       val_reg  [CAPACITY];
    logic [VALUE_W-1:0]       val_next [CAPACITY];
    logic [PRIORITY_BITS-1:0] pri_reg  [CAPACITY];
    logic [PRIORITY_BITS-1:0] pri_next [CAPACITY];
    logic [CAPACITY-1:0]      ge;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                full;
    logic                empty;
    logic                do_insert;
    logic                do_remove;

    logic [VALUE_W-1:0]  res_value_reg;
    logic [VALUE_W-1:0]  res_value_next;
    logic [STATUS_W-1:0] res_status_reg;
    logic [STATUS_W-1:0] res_status_next;
    logic [CNT_W-1:0]    res_occ_reg;
    logic                res_valid_reg;
    logic                res_valid_next;

    assign prio_ext = {{PRIORITY_BITS{1'b0}}, priority_req};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_op_reg    <= op;
            in_value_reg <= value;
            in_prio_reg  <= prio_ext[PRIORITY_BITS-1:0];
        end
    end

    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign do_insert = cmd.execute && (in_op_reg == OP_INSERT) && !full;
    assign do_remove = cmd.execute && (in_op_reg == OP_REMOVE) && !empty;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            ge[i] = (CNT_W'(i) < count_reg) && (pri_reg[i] >= in_prio_reg);
        end
    end

    // cell i keeps, loads the new entry, or takes a neighbor
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic open_here;
        logic [VALUE_W-1:0]       up_val;
        logic [PRIORITY_BITS-1:0] up_pri;
        logic [VALUE_W-1:0]       dn_val;
        logic [PRIORITY_BITS-1:0] dn_pri;

        if (i == 0)
        begin : g_head
            assign open_here = 1'b1;
            assign up_val    = in_value_reg;
            assign up_pri    = in_prio_reg;
        end
        else
        begin : g_body
            assign open_here = ge[i-1];
            assign up_val    = val_reg[i-1];
            assign up_pri    = pri_reg[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign dn_val = val_reg[i];
            assign dn_pri = pri_reg[i];
        end
        else
        begin : g_inner
            assign dn_val = val_reg[i+1];
            assign dn_pri = pri_reg[i+1];
        end

        always_comb
        begin
            val_next[i] = val_reg[i];
            pri_next[i] = pri_reg[i];
            if (do_insert && !ge[i])
            begin
                if (open_here)
                begin
                    val_next[i] = in_value_reg;
                    pri_next[i] = in_prio_reg;
                end
                else
                begin
                    val_next[i] = up_val;
                    pri_next[i] = up_pri;
                end
            end
            else if (do_remove)
            begin
                val_next[i] = dn_val;
                pri_next[i] = dn_pri;
            end
        end

        always_ff @(posedge clk)
        begin
            val_reg[i] <= val_next[i];
            pri_reg[i] <= pri_next[i];
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        res_value_next  = '0;
        res_status_next = STAT_OK;
        if (in_op_reg == OP_INSERT)
        begin
            if (full)
            begin
                res_status_next = STAT_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                res_value_next  = '1;
                res_status_next = STAT_EMPTY;
            end
            else
            begin
                res_value_next = val_reg[0];
                count_next     = count_reg - CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.execute)
        begin
            res_valid_next = 1'b1;
        end
        else if (cmd.retire)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (cmd.execute)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            res_value_reg  <= res_value_next;
            res_status_reg <= res_status_next;
            res_occ_reg    <= count_next;
        end
    end

    assign stat.res_valid = res_valid_reg;
    assign out_value      = res_value_reg;
    assign status         = res_status_reg;
    assign occupancy      = res_occ_reg;

endmodule

>>> rtl/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Stable sorted priority queue
// Sorted store of (value, priority) entries with insert and remove requests.
// ----------------------------------------------------------------------------
// Each request beat is first captured into the request registers; then, in the
// execute state, every cell of the sorted row compares its priority with the
// new one and shifts in parallel. The next request is taken only once the
// output register is free, at the earliest in the same cycle that the previous
// result beat is taken, so no request is taken while one executes, and a
// stalled result holds off the request channel. Larger priority numbers come
// out first; equal priorities leave in arrival order. Remove on empty returns
// -1 with an empty status, insert on full is dropped with a full status.
`include "stable_sorted_priority_queue_defines.svh"

module stable_sorted_priority_queue #(
    parameter int CAPACITY      = sspq_pkg::DEF_CAPACITY,
    parameter int PRIORITY_BITS = sspq_pkg::DEF_PRIORITY_BITS,
    parameter int OCC_W         = $clog2(CAPACITY + 1)
) (
    input  logic       clk,
    input  logic       rst_n,
    sspq_in_if.sink    req,
    sspq_out_if.source rsp
);
    import sspq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sspq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sspq_datapath #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS),
        .CNT_W         (OCC_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (req.op),
        .value        (req.value),
        .priority_req (req.priority_req),
        .out_value    (rsp.out_value),
        .status       (rsp.status),
        .occupancy    (rsp.occupancy)
    );

    assign rsp.valid = stat.res_valid;

    `SSPQ_ASSERT(a_busy_after_accept, req.valid && req.ready |=> !req.ready, "ready after accept")
    `SSPQ_ASSERT(a_full_occ, rsp.valid && rsp.status == STAT_FULL |-> rsp.occupancy == OCC_W'(CAPACITY), "full status with room")
    `SSPQ_ASSERT(a_empty_res, rsp.valid && rsp.status == STAT_EMPTY |-> rsp.occupancy == '0 && rsp.out_value == -32'sd1, "bad empty result")
    `SSPQ_ASSERT(a_exec_slot, cmd.execute |-> !stat.res_valid || $past(rsp.ready), "result overwritten")

endmodule
